// ===== hw/rtl/ghd_pkg.sv =====
// Package for the grid histogram deposit block: grid geometry, field widths,
// status and register codes, and the per-axis result type.
// Used by ghd_axis.sv and grid_histogram_deposit_top.sv.
package ghd_pkg;

	localparam int unsigned GRID_X_BITS = 4;
	localparam int unsigned GRID_Y_BITS = 4;
	localparam int unsigned GRID_Z_BITS = 4;

	localparam int unsigned GRID_X_SIZE = 1 << GRID_X_BITS;
	localparam int unsigned GRID_Y_SIZE = 1 << GRID_Y_BITS;
	localparam int unsigned GRID_Z_SIZE = 1 << GRID_Z_BITS;
	localparam int unsigned FLAT_BITS   = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned DIFF_W  = COORD_W + 1;
	localparam int unsigned QUOT_W  = 32;
	localparam int unsigned MASS_W  = 32;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned DEPTH   = 1 << IDX_W;
	localparam int unsigned VALUE_W = 48;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [MASS_W-1:0] ONE_Q16 = MASS_W'(32'h0001_0000);

	localparam logic OP_DEPOSIT = 1'b0;
	localparam logic OP_READ    = 1'b1;

	typedef enum logic [1:0] {
		ST_DEPOSIT = 2'd0,
		ST_REFUSED = 2'd1,
		ST_READ    = 2'd2
	} ghd_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_ORIGIN      = 3'd0,
		CFG_Y_ORIGIN      = 3'd1,
		CFG_Z_ORIGIN      = 3'd2,
		CFG_X_INV_SPACING = 3'd3,
		CFG_Y_INV_SPACING = 3'd4,
		CFG_Z_INV_SPACING = 3'd5,
		CFG_WEIGHT_MODE   = 3'd6
	} ghd_cfg_idx_t;

	// One axis after the multiply: below-origin flag and integer part of the product.
	typedef struct packed {
		logic              below;
		logic [QUOT_W-1:0] quot;
	} ghd_axis_t;

endpackage

// ===== hw/rtl/ghd_axis.sv =====
// One axis of the bin index calculation: offset from the origin, then the
// exact product with the inverse spacing, two register stages. Uses ghd_pkg.
module ghd_axis import ghd_pkg::*; (
	input  logic                      clk,
	input  logic                      adv,
	input  logic signed [COORD_W-1:0] coord,
	input  logic signed [COORD_W-1:0] origin,
	input  logic        [COORD_W-1:0] inv_spacing,
	output ghd_axis_t                 res_s2
);

	logic signed [DIFF_W-1:0] diff_s1;
	logic [2*QUOT_W-1:0]      prod;

	// A nonnegative offset fits in 32 bits, so the low bits feed the multiplier.
	assign prod = (2*QUOT_W)'(diff_s1[COORD_W-1:0]) * (2*QUOT_W)'(inv_spacing);

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1      <= DIFF_W'(coord) - DIFF_W'(origin);
			res_s2.below <= diff_s1[DIFF_W-1];
			res_s2.quot  <= prod[2*QUOT_W-1:QUOT_W];
		end
	end

endmodule

// ===== hw/rtl/grid_histogram_deposit_top.sv =====
// Top level of the grid histogram deposit block: configuration registers,
// the bin store with its clearing pass, and the read-modify-write pipeline.
// Depends on ghd_pkg and ghd_axis.
//
// Usage. Items enter on the item channel (item_valid / item_stall) and each
// gives exactly one result on the result channel (result_valid / result_stall).
// A deposit item carries a particle position and mass; its bin on each axis is
// floor((coord - origin) * inv_spacing), and the bin gains 1.0 or the mass,
// saturating at the top of the 48-bit range. A particle below an origin or
// past the far edge is refused with a status and zero fields. A read item
// returns the content of one bin. Registers are written on the cfg channel
// (cfg_valid / cfg_ready, always ready) by the user only while no item is in
// flight; the block itself does not enforce this.
// Timing. One item is taken per cycle while item_stall is low; the pipeline is
// offset, multiply, store read, then add and write back into the output register.
// The store is a single-port-write, registered-read memory; a deposit that
// reads a bin written by the item just ahead of it takes the sum from the
// last-write register instead of the stale memory word.
// Reset. After arst_n is released the store is cleared one entry per cycle,
// all 4096 entries in turn, with item_stall held high; configuration writes are
// still taken during that time.
// Backpressure. When result_stall is high and a result is waiting, the whole
// pipeline holds and item_stall goes high until the result is taken.
module grid_histogram_deposit_top import ghd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]               cfg_data,
	// item channel
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      operation,
	input  logic signed [COORD_W-1:0] coord_a,
	input  logic signed [COORD_W-1:0] coord_b,
	input  logic signed [COORD_W-1:0] coord_c,
	input  logic [MASS_W-1:0]         particle_mass,
	input  logic [IDX_W-1:0]          read_index,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [1:0]                status,
	output logic [IDX_W-1:0]          bin_number,
	output logic [VALUE_W-1:0]        bin_value
);

	// Configuration registers.
	logic signed [COORD_W-1:0] x_origin_q, y_origin_q, z_origin_q;
	logic [COORD_W-1:0]        x_inv_q, y_inv_q, z_inv_q;
	logic                      weight_mode_q;

	// Clearing pass state.
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// Pipeline control and payload.
	logic                adv;
	logic                accept;
	logic                v_s1, v_s2, v_s3, out_vld_q;
	logic                op_s1, op_s2, op_s3;
	logic [MASS_W-1:0]   mass_s1, mass_s2, mass_s3;
	logic [IDX_W-1:0]    ridx_s1, ridx_s2;
	logic                ok_s3;
	logic [IDX_W-1:0]    addr_s3;
	logic [VALUE_W-1:0]  rd_s3;

	ghd_axis_t ax_x_s2, ax_y_s2, ax_z_s2;

	// Stage 2 index logic.
	logic                   ok_x, ok_y, ok_z, ok_all;
	logic [GRID_X_BITS-1:0] idx_x;
	logic [GRID_Y_BITS-1:0] idx_y;
	logic [GRID_Z_BITS-1:0] idx_z;
	logic [FLAT_BITS-1:0]   flat_wide;
	logic [IDX_W-1:0]       rd_addr;

	// Stage 3 update logic.
	logic [VALUE_W-1:0] base;
	logic [MASS_W-1:0]  add_val;
	logic [VALUE_W:0]   sum_wide;
	logic [VALUE_W-1:0] sum_sat;
	logic               dep_wr;

	// Store write port and last-write register.
	logic [VALUE_W-1:0] mem [DEPTH];
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               lw_vld_q;
	logic [IDX_W-1:0]   lw_addr_q;
	logic [VALUE_W-1:0] lw_data_q;

	// Result register.
	ghd_status_t        status_q;
	logic [IDX_W-1:0]   number_q;
	logic [VALUE_W-1:0] value_q;

	assign cfg_ready    = 1'b1;
	assign adv          = !out_vld_q || !result_stall;
	assign item_stall   = clr_busy_q || !adv;
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_vld_q;
	assign status       = status_q;
	assign bin_number   = number_q;
	assign bin_value    = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q    <= '0;
			y_origin_q    <= '0;
			z_origin_q    <= '0;
			x_inv_q       <= COORD_W'(32'h0001_0000);
			y_inv_q       <= COORD_W'(32'h0001_0000);
			z_inv_q       <= COORD_W'(32'h0001_0000);
			weight_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_X_ORIGIN:      x_origin_q    <= cfg_data;
				CFG_Y_ORIGIN:      y_origin_q    <= cfg_data;
				CFG_Z_ORIGIN:      z_origin_q    <= cfg_data;
				CFG_X_INV_SPACING: x_inv_q       <= cfg_data;
				CFG_Y_INV_SPACING: y_inv_q       <= cfg_data;
				CFG_Z_INV_SPACING: z_inv_q       <= cfg_data;
				CFG_WEIGHT_MODE:   weight_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The clearing pass walks every store entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (clr_cnt_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage valids: the whole pipeline moves together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= accept;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_vld_q <= v_s3;
		end
	end

	ghd_axis u_axis_x (
		.clk         (clk),
		.adv         (adv),
		.coord       (coord_a),
		.origin      (x_origin_q),
		.inv_spacing (x_inv_q),
		.res_s2      (ax_x_s2)
	);

	ghd_axis u_axis_y (
		.clk         (clk),
		.adv         (adv),
		.coord       (coord_b),
		.origin      (y_origin_q),
		.inv_spacing (y_inv_q),
		.res_s2      (ax_y_s2)
	);

	ghd_axis u_axis_z (
		.clk         (clk),
		.adv         (adv),
		.coord       (coord_c),
		.origin      (z_origin_q),
		.inv_spacing (z_inv_q),
		.res_s2      (ax_z_s2)
	);

	// An index equal to the axis size is the far edge and folds into the last bin.
	always_comb begin
		ok_x = !ax_x_s2.below && (ax_x_s2.quot <= QUOT_W'(GRID_X_SIZE));
		ok_y = !ax_y_s2.below && (ax_y_s2.quot <= QUOT_W'(GRID_Y_SIZE));
		ok_z = !ax_z_s2.below && (ax_z_s2.quot <= QUOT_W'(GRID_Z_SIZE));
		ok_all = ok_x && ok_y && ok_z;
		idx_x = (ax_x_s2.quot == QUOT_W'(GRID_X_SIZE)) ? GRID_X_BITS'(GRID_X_SIZE - 1)
			: ax_x_s2.quot[GRID_X_BITS-1:0];
		idx_y = (ax_y_s2.quot == QUOT_W'(GRID_Y_SIZE)) ? GRID_Y_BITS'(GRID_Y_SIZE - 1)
			: ax_y_s2.quot[GRID_Y_BITS-1:0];
		idx_z = (ax_z_s2.quot == QUOT_W'(GRID_Z_SIZE)) ? GRID_Z_BITS'(GRID_Z_SIZE - 1)
			: ax_z_s2.quot[GRID_Z_BITS-1:0];
		// Large grids wrap modulo the store depth; small ones zero-extend.
		flat_wide = {idx_z, idx_y, idx_x};
		rd_addr   = (op_s2 == OP_READ) ? ridx_s2 : IDX_W'(flat_wide);
	end

	// Payload pipeline, no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= operation;
			mass_s1 <= particle_mass;
			ridx_s1 <= read_index;
			op_s2   <= op_s1;
			mass_s2 <= mass_s1;
			ridx_s2 <= ridx_s1;
			op_s3   <= op_s2;
			mass_s3 <= mass_s2;
			ok_s3   <= ok_all;
			addr_s3 <= rd_addr;
		end
	end

	// Registered read port; it advances with the pipeline so a held item keeps its data.
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			rd_s3 <= mem[rd_addr];
		end
	end

	// The item just ahead may have written this bin on the edge our read was taken.
	always_comb begin
		base     = (lw_vld_q && (lw_addr_q == addr_s3)) ? lw_data_q : rd_s3;
		add_val  = weight_mode_q ? mass_s3 : ONE_Q16;
		sum_wide = {1'b0, base} + (VALUE_W + 1)'(add_val);
		sum_sat  = sum_wide[VALUE_W] ? '1 : sum_wide[VALUE_W-1:0];
		dep_wr   = adv && v_s3 && (op_s3 == OP_DEPOSIT) && ok_s3;
	end

	always_comb begin
		wr_en   = clr_busy_q || dep_wr;
		wr_addr = clr_busy_q ? clr_cnt_q : addr_s3;
		wr_data = clr_busy_q ? '0 : sum_sat;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_vld_q <= 1'b0;
		end else if (dep_wr) begin
			lw_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dep_wr) begin
			lw_addr_q <= addr_s3;
			lw_data_q <= sum_sat;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			priority if (op_s3 == OP_READ) begin
				status_q <= ST_READ;
				number_q <= addr_s3;
				value_q  <= base;
			end else if (ok_s3) begin
				status_q <= ST_DEPOSIT;
				number_q <= addr_s3;
				value_q  <= sum_sat;
			end else begin
				status_q <= ST_REFUSED;
				number_q <= '0;
				value_q  <= '0;
			end
		end
	end

	// No item may be in flight while the clearing pass owns the store.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !(v_s1 || v_s2 || v_s3 || out_vld_q))
		else $error("item in pipeline during clearing pass");

	// The clearing pass ends only after the last entry.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy_q) |-> ($past(clr_cnt_q) == '1))
		else $error("clearing pass ended early");

	// A refused particle reports zero fields.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (status_q == ST_REFUSED)) |-> ((number_q == '0) && (value_q == '0)))
		else $error("refused result carries data");

	// In counting mode a deposited bin can never read back as zero.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && (status_q == ST_DEPOSIT) && !weight_mode_q) |-> (value_q != '0))
		else $error("counting deposit returned zero");

	// The store is never written by a deposit while it is being cleared.
	a_no_dep_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !dep_wr)
		else $error("deposit write during clearing pass");

endmodule

// ===== tb/grid_histogram_deposit_top_tb.sv =====
// Self-checking testbench for the grid histogram deposit block: drives particle and read
// items with random idling and back-pressure and checks every result against a
// predictor with its own copy of the bin store. Depends on ghd_pkg and the block's RTL.
module grid_histogram_deposit_top_tb import ghd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// An index that names no register; a write to it must leave every register alone.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 8;
	localparam int HEAVY_COUNT = 100;

	// One item as the sender sees it.
	typedef struct {
		logic                op;
		logic [COORD_W-1:0]  a;
		logic [COORD_W-1:0]  b;
		logic [COORD_W-1:0]  c;
		logic [MASS_W-1:0]   mass;
		logic [IDX_W-1:0]    ridx;
	} particle_item_t;

	// One result as the block should deliver it.
	typedef struct packed {
		logic [1:0]          status;
		logic [IDX_W-1:0]    bin;
		logic [VALUE_W-1:0]  value;
	} bin_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [31:0]               cfg_data;
	logic                      item_valid;
	logic                      item_stall;
	logic                      operation;
	logic signed [COORD_W-1:0] coord_a;
	logic signed [COORD_W-1:0] coord_b;
	logic signed [COORD_W-1:0] coord_c;
	logic [MASS_W-1:0]         particle_mass;
	logic [IDX_W-1:0]          read_index;
	logic                      result_valid;
	logic                      result_stall;
	logic [1:0]                status;
	logic [IDX_W-1:0]          bin_number;
	logic [VALUE_W-1:0]        bin_value;

	// Predictor state: the register copies and the mirror of the bin store.
	logic [31:0]        grid_origin [3];
	logic [31:0]        grid_inv [3];
	logic               mass_mode;
	logic [VALUE_W-1:0] bin_mirror [DEPTH];
	int unsigned        recent_bin;

	// Results predicted for accepted items, oldest first.
	bin_result_t pending_bins [$];

	// Stimulus knobs shared by the sender and the stall process.
	int sender_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int axis_shift [3];
	int fail_count;

	grid_histogram_deposit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.coord_a      (coord_a),
		.coord_b      (coord_b),
		.coord_c      (coord_c),
		.particle_mass(particle_mass),
		.read_index   (read_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.bin_number   (bin_number),
		.bin_value    (bin_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run should finish long before this; reaching it means the block hung.
	initial begin
		#10_000_000;
		$display("grid_histogram_deposit_top: mismatch");
		$finish;
	end

	// Bin index along one axis: floor((coord - origin) * inv) taken from the exact
	// Q32.32 product. Returns 0 when the particle is below the origin or past the far
	// edge. An index equal to the axis size is pulled back onto the last bin.
	function automatic logic axis_bin(input logic [31:0] coord, input logic [31:0] origin,
			input logic [31:0] inv, input int unsigned bits, output logic [31:0] idx);
		longint     diff;
		logic [63:0] span;
		logic [63:0] prod;
		logic [63:0] quot;
		logic [63:0] size;
		idx = '0;
		diff = longint'($signed(coord)) - longint'($signed(origin));
		if (diff < 0)
			return 1'b0;
		span = 64'(diff);
		prod = span * {32'd0, inv};
		quot = prod >> 32;
		size = 64'd1 << bits;
		if (quot > size)
			return 1'b0;
		if (quot == size)
			quot = size - 64'd1;
		idx = quot[31:0];
		return 1'b1;
	endfunction

	// Works out the result of one accepted item and updates the mirrored store.
	function automatic bin_result_t predict_bin(input particle_item_t it);
		bin_result_t     r;
		logic [31:0]     ix, iy, iz;
		logic            okx, oky, okz;
		int unsigned     flat;
		logic [VALUE_W:0] sum;
		if (it.op == OP_READ) begin
			r.status = ST_READ;
			r.bin = it.ridx;
			r.value = bin_mirror[it.ridx];
			return r;
		end
		okx = axis_bin(it.a, grid_origin[0], grid_inv[0], GRID_X_BITS, ix);
		oky = axis_bin(it.b, grid_origin[1], grid_inv[1], GRID_Y_BITS, iy);
		okz = axis_bin(it.c, grid_origin[2], grid_inv[2], GRID_Z_BITS, iz);
		if (!(okx && oky && okz)) begin
			r.status = ST_REFUSED;
			r.bin = '0;
			r.value = '0;
			return r;
		end
		flat = (ix + (iy << GRID_X_BITS) + (iz << (GRID_X_BITS + GRID_Y_BITS))) % DEPTH;
		sum = {1'b0, bin_mirror[flat]} + (mass_mode ? it.mass : ONE_Q16);
		if (sum[VALUE_W])
			sum[VALUE_W-1:0] = '1;
		bin_mirror[flat] = sum[VALUE_W-1:0];
		recent_bin = flat;
		r.status = ST_DEPOSIT;
		r.bin = flat[IDX_W-1:0];
		r.value = sum[VALUE_W-1:0];
		return r;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		case (idx)
			CFG_X_ORIGIN:      grid_origin[0] = v;
			CFG_Y_ORIGIN:      grid_origin[1] = v;
			CFG_Z_ORIGIN:      grid_origin[2] = v;
			CFG_X_INV_SPACING: grid_inv[0] = v;
			CFG_Y_INV_SPACING: grid_inv[1] = v;
			CFG_Z_INV_SPACING: grid_inv[2] = v;
			CFG_WEIGHT_MODE:   mass_mode = v[0];
			default: ;
		endcase
	endfunction

	function automatic particle_item_t deposit_item(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] mass);
		particle_item_t it;
		it.op = OP_DEPOSIT;
		it.a = a;
		it.b = b;
		it.c = c;
		it.mass = mass;
		it.ridx = IDX_W'($urandom);
		return it;
	endfunction

	function automatic particle_item_t read_item(input logic [IDX_W-1:0] idx);
		particle_item_t it;
		it.op = OP_READ;
		it.a = $urandom;
		it.b = $urandom;
		it.c = $urandom;
		it.mass = $urandom;
		it.ridx = idx;
		return it;
	endfunction

	// A coordinate for one axis of the current random setting. Most land inside the
	// grid, some around the far edge, some just below the origin, a few anywhere.
	function automatic logic [31:0] gen_coord(input int ax);
		longint width;
		longint off;
		int     pick;
		width = longint'(1) << axis_shift[ax];
		pick = $urandom_range(99);
		if (pick < 80)
			off = longint'($urandom) % (16 * width);
		else if (pick < 88)
			off = 15 * width + longint'($urandom) % (3 * width);
		else if (pick < 94)
			off = -longint'($urandom_range(1000, 1));
		else
			return $urandom;
		off = off + longint'($signed(grid_origin[ax]));
		if (off > 64'sd2147483647 || off < -64'sd2147483648)
			return $urandom;
		return off[31:0];
	endfunction

	// Register write on the configuration channel. The channel is then left idle
	// before the task returns, so that valid never drops and rises in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one item, possibly after some idle cycles, and holds it until taken.
	// Valid is left high so that a following item goes out back to back.
	task automatic send_particle(input particle_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= it.op;
		coord_a <= it.a;
		coord_b <= it.b;
		coord_c <= it.c;
		particle_mass <= it.mass;
		read_index <= it.ridx;
		do @(posedge clk); while (item_stall);
		pending_bins.push_back(predict_bin(it));
	endtask

	// Stops offering items and waits until every predicted result has come back.
	task automatic drain_results(input int settle);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_bins.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Receiver side: random stalls, or a long hold-off while hold_left counts down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin : check_results
		bin_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_bins.size() == 0) begin
				$error("unexpected result: status %0d bin_number %0d bin_value %0h",
					status, bin_number, bin_value);
				fail_count++;
			end else begin
				want = pending_bins.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (bin_number !== want.bin) begin
					$error("bin_number: expected %0d, actual %0d", want.bin, bin_number);
					fail_count++;
				end
				if (bin_value !== want.value) begin
					$error("bin_value: expected %0h, actual %0h", want.value, bin_value);
					fail_count++;
				end
			end
		end
	end

	// Reset settings, unit bins: deposits, the far edge, refusals and reads.
	task automatic test_unit_grid();
		// Two hits on bin 0 in a row exercise the forwarding of the last write.
		send_particle(deposit_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, $urandom));
		send_particle(deposit_item(32'h0000_8000, 32'h0000_ffff, 32'h0000_0001, $urandom));
		send_particle(deposit_item(32'h000f_8000, 32'h000f_8000, 32'h000f_8000, $urandom));
		// Exactly on the far edge, and just past it, both land on the last bin.
		send_particle(deposit_item(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, $urandom));
		send_particle(deposit_item(32'h0010_0001, 32'h0010_ffff, 32'h0010_0000, $urandom));
		// One full bin past the edge is refused.
		send_particle(deposit_item(32'h0011_0000, 32'h0000_0000, 32'h0000_0000, $urandom));
		// Below the origin by one step and at the most negative value; past the edge at the most positive.
		send_particle(deposit_item(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, $urandom));
		send_particle(deposit_item(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, $urandom));
		send_particle(deposit_item(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000, $urandom));
		// Reads of touched bins, and of one that has stayed cleared since reset.
		send_particle(read_item(12'd0));
		send_particle(read_item(12'hfff));
		send_particle(read_item(12'h4d2));
	endtask

	// Mass weighting with the largest and the smallest mass.
	task automatic test_mass_weight();
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_WEIGHT_MODE, 32'd1);
		send_particle(deposit_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_ffff));
		send_particle(deposit_item(32'h0001_4000, 32'h0002_c000, 32'h0003_0001, 32'h0000_0000));
		send_particle(read_item(12'd801));
	endtask

	// Extreme register values: origins at both ends of the range, the smallest and the
	// largest spacing reciprocal, and a zero reciprocal that folds an axis onto bin 0.
	task automatic test_register_extremes();
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_X_ORIGIN, 32'h8000_0000);
		write_reg(CFG_Y_ORIGIN, 32'h7fff_ffff);
		write_reg(CFG_Z_ORIGIN, 32'h0000_0000);
		write_reg(CFG_X_INV_SPACING, 32'h0000_0001);
		write_reg(CFG_Y_INV_SPACING, 32'hffff_ffff);
		write_reg(CFG_Z_INV_SPACING, 32'h0000_0000);
		send_particle(deposit_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678));
		send_particle(deposit_item(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001));
		send_particle(deposit_item(32'h0000_0000, 32'h7fff_fffe, 32'h0000_0000, 32'h0000_0001));
		send_particle(deposit_item(32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001));
		// With the largest reciprocal a raw step of 16 maps to index 15, 17 to the edge.
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_X_INV_SPACING, 32'hffff_ffff);
		send_particle(deposit_item(32'h8000_000f, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0002));
		send_particle(deposit_item(32'h8000_0010, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0002));
		send_particle(deposit_item(32'h8000_0011, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0002));
		send_particle(deposit_item(32'h8000_0012, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0002));
		// A write to an index with no register behind it changes nothing.
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_UNUSED, 32'hdead_beef);
		send_particle(deposit_item(32'h8000_0010, 32'h7fff_ffff, 32'h0000_0005, 32'h0000_0003));
	endtask

	// Back-to-back largest-mass deposits on one bin carry its sum well past 32 bits
	// and keep the last-write forwarding busy on every item.
	task automatic test_heavy_bin();
		drain_results(SETTLE_CYCLES);
		write_reg(CFG_X_ORIGIN, 32'h0000_0000);
		write_reg(CFG_Y_ORIGIN, 32'h0000_0000);
		write_reg(CFG_X_INV_SPACING, ONE_Q16);
		write_reg(CFG_Y_INV_SPACING, ONE_Q16);
		write_reg(CFG_Z_INV_SPACING, ONE_Q16);
		write_reg(CFG_WEIGHT_MODE, 32'd1);
		for (int n = 0; n < HEAVY_COUNT; n++)
			send_particle(deposit_item(32'h0002_0000, 32'h0000_8000, 32'h0000_0000,
				32'hffff_ffff));
		send_particle(read_item(12'd2));
	endtask

	// One random phase: a fresh random setting, then mostly well-formed items with
	// random content plus a share of noise. Now and then the sender waits for the
	// pipeline to empty completely before going on.
	task automatic test_random_phase(input int count, input int idle_pct, input int stall_pct,
			input logic wmode);
		logic [31:0]    org;
		logic [31:0]    inv;
		int             pick;
		particle_item_t it;
		drain_results(SETTLE_CYCLES);
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		for (int ax = 0; ax < 3; ax++) begin
			pick = $urandom_range(9);
			axis_shift[ax] = (pick == 0) ? 0 : (pick == 1) ? 20 : $urandom_range(16, 4);
			org = $urandom;
			org[30] = org[31];
			inv = (axis_shift[ax] == 0) ? 32'hffff_ffff : (32'd1 << (32 - axis_shift[ax]));
			if ($urandom_range(3) == 0 && axis_shift[ax] != 0)
				inv = inv + $urandom_range(7);
			write_reg(logic'(ax == 0) ? CFG_X_ORIGIN : (ax == 1) ? CFG_Y_ORIGIN : CFG_Z_ORIGIN,
				org);
			write_reg((ax == 0) ? CFG_X_INV_SPACING : (ax == 1) ? CFG_Y_INV_SPACING :
				CFG_Z_INV_SPACING, inv);
		end
		write_reg(CFG_WEIGHT_MODE, {31'd0, wmode});
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				it.op = 1'($urandom);
				it.a = $urandom;
				it.b = $urandom;
				it.c = $urandom;
				it.mass = $urandom;
				it.ridx = IDX_W'($urandom);
			end else if (pick < 28) begin
				it = read_item(($urandom_range(1) == 0) ? IDX_W'(recent_bin) : IDX_W'($urandom));
			end else begin
				pick = $urandom_range(9);
				it = deposit_item(gen_coord(0), gen_coord(1), gen_coord(2),
					(pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom);
			end
			send_particle(it);
			if ($urandom_range(199) == 0)
				drain_results(0);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering, so the
	// pipeline fills and the input stalls. Then the sender pauses until all is back.
	task automatic test_backpressure();
		drain_results(SETTLE_CYCLES);
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 400;
		for (int n = 0; n < 40; n++)
			send_particle(deposit_item(gen_coord(0), gen_coord(1), gen_coord(2), $urandom));
		drain_results(0);
		for (int n = 0; n < 20; n++)
			send_particle(($urandom_range(3) == 0) ? read_item(IDX_W'(recent_bin)) :
				deposit_item(gen_coord(0), gen_coord(1), gen_coord(2), $urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		operation = OP_DEPOSIT;
		coord_a = '0;
		coord_b = '0;
		coord_c = '0;
		particle_mass = '0;
		read_index = '0;
		result_stall = 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		fail_count = 0;
		recent_bin = 0;
		// Register values after reset, and a store cleared to zero.
		grid_origin = '{32'd0, 32'd0, 32'd0};
		grid_inv = '{ONE_Q16, ONE_Q16, ONE_Q16};
		mass_mode = 1'b0;
		axis_shift = '{16, 16, 16};
		for (int n = 0; n < DEPTH; n++)
			bin_mirror[n] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first items wait out the clearing pass behind item_stall.
		test_unit_grid();
		test_mass_weight();
		test_register_extremes();
		test_heavy_bin();
		test_random_phase(500, 0, 0, 1'b0);
		test_random_phase(500, 78, 0, 1'b1);
		test_random_phase(500, 0, 78, 1'b0);
		test_random_phase(500, 12, 12, 1'b1);
		test_backpressure();
		drain_results(SETTLE_CYCLES);

		if (fail_count == 0)
			$display("grid_histogram_deposit_top: match");
		else
			$display("grid_histogram_deposit_top: mismatch");
		$finish;
	end

endmodule
